### rtl/slv_pkg.sv
package slv_pkg;

  typedef enum logic [1:0] {
    VERDICT_OK  = 2'd0,
    VERDICT_ERR = 2'd1,
    VERDICT_BAD = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_OK        = 2'd1,
    REASON_REFUSED   = 2'd2,
    REASON_UNCERTAIN = 2'd3
  } reason_e;

  typedef struct packed {
    verdict_e    verdict;
    logic [63:0] revision;
    logic        durable_flag;
  } slv_result_t;

  // token positions on the line
  localparam logic [2:0] TOK_KIND     = 3'd0;
  localparam logic [2:0] TOK_REVISION = 3'd1;
  localparam logic [2:0] TOK_ACTIVE   = 3'd2;
  localparam logic [2:0] TOK_ROLLBACK = 3'd3;
  localparam logic [2:0] TOK_STAGED   = 3'd4;
  localparam logic [2:0] TOK_DURABLE  = 3'd5;
  localparam logic [2:0] TOK_REASON   = 3'd6;
  localparam logic [2:0] TOK_EXTRA    = 3'd7;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic [6:0] OFFSET_MAX = 7'd127;
  localparam logic [6:0] DIGEST_LEN = 7'd64;
  localparam logic [6:0] KIND_OK_LEN  = 7'd2;
  localparam logic [6:0] KIND_ERR_LEN = 7'd3;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F);
  endfunction

  function automatic logic [6:0] prefix_len(input logic [2:0] idx);
    logic [6:0] len;
    case (idx)
      TOK_REVISION: len = 7'd9;
      TOK_ACTIVE:   len = 7'd7;
      TOK_ROLLBACK: len = 7'd9;
      TOK_STAGED:   len = 7'd7;
      TOK_DURABLE:  len = 7'd8;
      TOK_REASON:   len = 7'd7;
      default:      len = 7'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [71:0] text;
    int          len;
    logic [7:0]  ch;
    case (idx)
      TOK_REVISION: begin text = "revision="; len = 9; end
      TOK_ACTIVE:   begin text = "active=";   len = 7; end
      TOK_ROLLBACK: begin text = "rollback="; len = 9; end
      TOK_STAGED:   begin text = "staged=";   len = 7; end
      TOK_DURABLE:  begin text = "durable=";  len = 8; end
      TOK_REASON:   begin text = "reason=";   len = 7; end
      default:      begin text = '0;          len = 0; end
    endcase
    if (int'(pos) < len) ch = text[8*(len-1-int'(pos)) +: 8];
    else ch = 8'h00;
    return ch;
  endfunction

  // k = 0 "OK", k = 1 "ERR"
  function automatic logic [7:0] kind_char(input logic k, input logic [1:0] pos);
    logic [23:0] text;
    int          len;
    logic [7:0]  ch;
    if (k) begin
      text = "ERR"; len = 3;
    end else begin
      text = {8'h00, "OK"}; len = 2;
    end
    if (int'(pos) < len) ch = text[8*(len-1-int'(pos)) +: 8];
    else ch = 8'h00;
    return ch;
  endfunction

  // k = 0 "ok", 1 "refused", 2 the uncertain-durability reason
  function automatic logic [6:0] reason_len(input logic [1:0] k);
    logic [6:0] len;
    case (k)
      2'd0:    len = 7'd2;
      2'd1:    len = 7'd7;
      2'd2:    len = 7'd20;
      default: len = 7'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] reason_char(input logic [1:0] k, input logic [4:0] pos);
    logic [159:0] text;
    int           len;
    logic [7:0]   ch;
    case (k)
      2'd0:    begin text = "ok";                       len = 2;  end
      2'd1:    begin text = "refused";                  len = 7;  end
      2'd2:    begin text = {"durability_", "uncertain"}; len = 20; end
      default: begin text = '0;                         len = 0;  end
    endcase
    if (int'(pos) < len) ch = text[8*(len-1-int'(pos)) +: 8];
    else ch = 8'h00;
    return ch;
  endfunction

endpackage

### rtl/slv_byte_if.sv
interface slv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       is_last;

  modport source (output valid, output byte_in, output is_last, input ready);
  modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

### rtl/slv_result_if.sv
interface slv_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] revision;
  logic        durable_flag;

  modport source (output valid, output verdict, output revision, output durable_flag,
                  input ready);
  modport sink   (input valid, input verdict, input revision, input durable_flag,
                  output ready);
endinterface

### rtl/slv_parser.sv
module slv_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output slv_pkg::slv_result_t res_o
);
  import slv_pkg::*;

  logic [2:0]  idx_q, idx_d;
  logic [6:0]  off_q, off_d;
  logic [63:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic        dur_q, dur_d;
  logic [3:0]  flags_q, flags_d;
  reason_e     reason_q, reason_d;
  logic        bad_q, bad_d;
  logic        psp_q, psp_d;

  logic [6:0]  plen;
  logic [6:0]  v;
  logic [3:0]  digit;
  logic [67:0] prod;
  logic        is_digit;

  // byte inside a token
  logic        tc_bad;
  logic [3:0]  tc_flags;
  logic [63:0] tc_acc;
  logic        tc_dur;

  // token end
  logic        et_bad;
  logic        et_err;
  reason_e     et_reason;

  // line end
  logic        fin_bad;

  assign plen     = prefix_len(idx_q);
  assign v        = off_q - plen;
  assign digit    = byte_i[3:0];
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  // acc * 10 + digit, carry bits flag overflow past 64 bits
  assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};

  always_comb begin
    logic [3:0] f;
    tc_bad   = 1'b0;
    tc_flags = flags_q;
    tc_acc   = acc_q;
    tc_dur   = dur_q;
    f        = flags_q;
    case (idx_q)
      TOK_KIND: begin
        f = (off_q == 7'd0) ? 4'd3 : flags_q;
        if (!(off_q < KIND_OK_LEN && byte_i == kind_char(1'b0, off_q[1:0]))) f[0] = 1'b0;
        if (!(off_q < KIND_ERR_LEN && byte_i == kind_char(1'b1, off_q[1:0]))) f[1] = 1'b0;
        tc_flags = f;
        if (f == 4'd0) tc_bad = 1'b1;
      end
      TOK_EXTRA: tc_bad = 1'b1;
      default: begin
        if (off_q < plen) begin
          if (byte_i != prefix_char(idx_q, off_q[3:0])) tc_bad = 1'b1;
        end else begin
          case (idx_q)
            TOK_REVISION: begin
              if (!is_digit) tc_bad = 1'b1;
              else if ((v == 7'd0 && digit == 4'd0) || (prod[67:64] != 4'd0)) tc_bad = 1'b1;
              else tc_acc = prod[63:0];
            end
            TOK_DURABLE: begin
              if (v == 7'd0 && (byte_i == CH_ZERO || byte_i == CH_ONE)) begin
                tc_dur = (byte_i == CH_ONE);
              end else begin
                tc_bad = 1'b1;
              end
            end
            TOK_REASON: begin
              f = (v == 7'd0) ? 4'd7 : flags_q;
              if (!(v < reason_len(2'd0) && byte_i == reason_char(2'd0, v[4:0]))) f[0] = 1'b0;
              if (!(v < reason_len(2'd1) && byte_i == reason_char(2'd1, v[4:0]))) f[1] = 1'b0;
              if (!(v < reason_len(2'd2) && byte_i == reason_char(2'd2, v[4:0]))) f[2] = 1'b0;
              tc_flags = f;
              if (f == 4'd0) tc_bad = 1'b1;
            end
            default: begin
              // digest: a lone dash or 64 hex chars
              if (v == 7'd0) begin
                if (byte_i == CH_DASH) tc_flags = 4'd1;
                else if (is_hex(byte_i)) tc_flags = 4'd0;
                else tc_bad = 1'b1;
              end else if (flags_q[0] || v >= DIGEST_LEN || !is_hex(byte_i)) begin
                tc_bad = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    et_bad    = 1'b0;
    et_err    = err_q;
    et_reason = reason_q;
    case (idx_q)
      TOK_KIND: begin
        if (flags_q[0] && off_q == KIND_OK_LEN) et_err = 1'b0;
        else if (flags_q[1] && off_q == KIND_ERR_LEN) et_err = 1'b1;
        else et_bad = 1'b1;
      end
      TOK_EXTRA: et_bad = 1'b1;
      default: begin
        if (off_q <= plen) begin
          et_bad = 1'b1;
        end else begin
          case (idx_q)
            TOK_REVISION: ;
            TOK_DURABLE: if (v != 7'd1) et_bad = 1'b1;
            TOK_REASON: begin
              et_reason = REASON_NONE;
              if (flags_q[0] && v == reason_len(2'd0)) et_reason = REASON_OK;
              if (flags_q[1] && v == reason_len(2'd1)) et_reason = REASON_REFUSED;
              if (flags_q[2] && v == reason_len(2'd2)) et_reason = REASON_UNCERTAIN;
              if (et_reason == REASON_NONE) et_bad = 1'b1;
            end
            default: begin
              if (!((flags_q[0] && v == 7'd1) || (!flags_q[0] && v == DIGEST_LEN))) begin
                et_bad = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    fin_bad = bad_q;
    if (!bad_q) begin
      if (byte_i != CH_NL || psp_q || off_q == 7'd0) begin
        fin_bad = 1'b1;
      end else begin
        fin_bad = et_bad || (idx_q != TOK_REASON);
      end
    end
    if (!fin_bad) begin
      if (!et_err && et_reason != REASON_OK) fin_bad = 1'b1;
      if (et_err && et_reason != REASON_REFUSED && et_reason != REASON_UNCERTAIN) fin_bad = 1'b1;
      if (et_reason == REASON_UNCERTAIN && dur_q) fin_bad = 1'b1;
    end
  end

  always_comb begin
    if (fin_bad) begin
      res_o.verdict      = VERDICT_BAD;
      res_o.revision     = 64'd0;
      res_o.durable_flag = 1'b0;
    end else begin
      res_o.verdict      = et_err ? VERDICT_ERR : VERDICT_OK;
      res_o.revision     = acc_q;
      res_o.durable_flag = dur_q;
    end
  end

  always_comb begin
    idx_d    = idx_q;
    off_d    = off_q;
    acc_d    = acc_q;
    err_d    = err_q;
    dur_d    = dur_q;
    flags_d  = flags_q;
    reason_d = reason_q;
    bad_d    = bad_q;
    psp_d    = psp_q;
    if (step_i) begin
      if (last_i) begin
        idx_d    = TOK_KIND;
        off_d    = 7'd0;
        acc_d    = 64'd0;
        err_d    = 1'b0;
        dur_d    = 1'b0;
        flags_d  = 4'd0;
        reason_d = REASON_NONE;
        bad_d    = 1'b0;
        psp_d    = 1'b0;
      end else if (!bad_q) begin
        if (byte_i < CH_PRINT_LO || byte_i > CH_PRINT_HI) begin
          bad_d = 1'b1;
        end else if (byte_i == CH_SPACE) begin
          if (off_q == 7'd0 || idx_q >= TOK_REASON) begin
            bad_d = 1'b1;
          end else begin
            bad_d    = et_bad;
            err_d    = et_err;
            reason_d = et_reason;
            idx_d    = idx_q + 3'd1;
            off_d    = 7'd0;
            flags_d  = 4'd0;
            psp_d    = 1'b1;
          end
        end else begin
          psp_d   = 1'b0;
          bad_d   = tc_bad;
          flags_d = tc_flags;
          acc_d   = tc_acc;
          dur_d   = tc_dur;
          if (off_q != OFFSET_MAX) off_d = off_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= TOK_KIND;
      off_q    <= 7'd0;
      acc_q    <= 64'd0;
      err_q    <= 1'b0;
      dur_q    <= 1'b0;
      flags_q  <= 4'd0;
      reason_q <= REASON_NONE;
      bad_q    <= 1'b0;
      psp_q    <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      off_q    <= off_d;
      acc_q    <= acc_d;
      err_q    <= err_d;
      dur_q    <= dur_d;
      flags_q  <= flags_d;
      reason_q <= reason_d;
      bad_q    <= bad_d;
      psp_q    <= psp_d;
    end
  end

endmodule

### rtl/status_line_validator_core.sv
// Result path: the last-byte beat is taken into the input register, and the parser loads its
//   verdict into the result register once that register is free; result_o shows that register.
// Throughput: one byte per cycle; the input side stalls only while a finished verdict
//   is held in the result register and the next last byte is waiting behind it.
// Reset: rst_ni clears the line state, the input valid and the result valid.
module status_line_validator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  slv_byte_if.sink     byte_i,
  slv_result_if.source result_o
);
  import slv_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_vld_q;
  slv_result_t out_q;
  slv_result_t res;
  logic        out_free;
  logic        step;

  assign out_free     = !out_vld_q || result_o.ready;
  assign step         = in_vld_q && (!in_last_q || out_free);
  assign byte_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.byte_in;
      in_last_q <= byte_i.is_last;
    end
  end

  slv_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) out_q <= res;
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.verdict      = out_q.verdict;
  assign result_o.revision     = out_q.revision;
  assign result_o.durable_flag = out_q.durable_flag;

  // a new verdict never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_last_q && out_vld_q) |-> result_o.ready)
    else $error("verdict overwritten before it was taken");

  // a held input beat keeps its byte until the parser consumes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("stalled input beat lost");

  // malformed verdict carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.verdict == VERDICT_BAD) |->
      (out_q.revision == 64'd0 && !out_q.durable_flag))
    else $error("malformed verdict with nonzero fields");

  // a result only follows a consumed last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(step && in_last_q))
    else $error("result without a last byte");

endmodule

### tb/status_line_validator_core_tb.sv
`timescale 1ns / 1ps

module status_line_validator_core_tb;
  import slv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int NUM_DIRECTED   = 25;
  localparam int PHASE_ITEMS    = 100;
  localparam int PHASE_LINES    = 1;

  typedef struct packed {
    logic        fixed;
    slv_result_t res;
  } dir_exp_t;

  localparam dir_exp_t USE_PARSER = '0;
  localparam dir_exp_t MALFORMED  = '{1'b1, '{VERDICT_BAD, 64'd0, 1'b0}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       src_valid  = 1'b0;
  logic [7:0] src_byte   = '0;
  logic       src_last   = 1'b0;
  logic       sink_ready = 1'b0;

  slv_byte_if   byte_if ();
  slv_result_if result_if ();

  assign byte_if.valid   = src_valid;
  assign byte_if.byte_in = src_byte;
  assign byte_if.is_last = src_last;
  assign result_if.ready = sink_ready;

  status_line_validator_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  string kind_word   [2] = '{"OK", "ERR"};
  string prefix_word [6] = '{"revision=", "active=", "rollback=", "staged=", "durable=",
                             "reason="};
  string reason_word [3] = '{"ok", "refused", {"durability_", "uncertain"}};
  string hex_chars       = "0123456789abcdef";

  int phase_idle  [4] = '{0, 84, 0, 6};
  int phase_stall [4] = '{0, 0, 84, 6};
  int idle_pct    = 0;
  int stall_pct   = 0;

  // '#' expands to a full 64-char digest, '%' to an overlong run of hex chars,
  // '@' to the uncertain-durability reason word
  string dir_line [NUM_DIRECTED] = '{
    "OK revision=1 active=- rollback=- staged=- durable=1 reason=ok\n",
    "ERR revision=18446744073709551615 active=- rollback=- staged=- durable=0 reason=refused\n",
    "ERR revision=42 active=- rollback=- staged=- durable=0 reason=@\n",
    "OK revision=987654321 active=- rollback=- staged=# durable=0 reason=ok\n",
    "ERR revision=10000000000000000000 active=- rollback=- staged=- durable=1 reason=refused\n",
    "ERR revision=7 active=- rollback=- staged=- durable=1 reason=@\n",
    "OK revision=18446744073709551616\n",
    "OK revision=0\n",
    "OK revision=012\n",
    "OK revision=5 active=- rollback=- staged=- durable=0 reason=refused\n",
    "ERR revision=5 active=- rollback=- staged=- durable=0 reason=ok\n",
    "\n",
    "OK revision=1 active=- rollback=- staged=- durable=1 reason=ok extra\n",
    "OK  revision=1\n",
    "OK \n",
    "OK revision=1\011\177\377 active=- y\n",
    "OK revision=1 active=-x rollback=-\n",
    "OK revision=1 active=abc rollback=-\n",
    "OK revision=1 active=%\n",
    "OK revision=1 active=- rollback=- staged=- durable=1 reason=ok",
    "ER revision=1\n",
    "OK revision=1 active=- rollback=- staged=- durable=2\n",
    "ERR revision=3 active=- rollback=- staged=- durable=0 reason=refuse\n",
    "OK revision=1 active=- rollback=- staged=- durable=1\n",
    " OK revision=1\n"
  };

  dir_exp_t dir_exp [NUM_DIRECTED] = '{
    '{1'b1, '{VERDICT_OK, 64'd1, 1'b1}},
    '{1'b1, '{VERDICT_ERR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
    '{1'b1, '{VERDICT_ERR, 64'd42, 1'b0}},
    USE_PARSER, USE_PARSER,
    MALFORMED, MALFORMED, MALFORMED, MALFORMED, MALFORMED,
    MALFORMED, MALFORMED, MALFORMED, MALFORMED, MALFORMED,
    MALFORMED, MALFORMED, MALFORMED, MALFORMED, MALFORMED,
    MALFORMED, MALFORMED, MALFORMED, MALFORMED, MALFORMED
  };

  logic [7:0]  line_buf [$];
  slv_result_t verdict_q [$];
  int          items_sent  = 0;
  int          mismatches  = 0;
  int          quiet_cycles = 0;

  // line parser state
  logic [2:0]  ln_tok;
  int          ln_off;
  logic [63:0] ln_rev;
  bit          ln_err;
  bit          ln_dur;
  logic [3:0]  ln_cand;
  reason_e     ln_reason;
  bit          ln_bad;
  bit          ln_space;

  function automatic bit hex_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_A:CH_F]};
  endfunction

  function automatic void clear_line();
    ln_tok    = TOK_KIND;
    ln_off    = 0;
    ln_rev    = '0;
    ln_err    = 1'b0;
    ln_dur    = 1'b0;
    ln_cand   = '0;
    ln_reason = REASON_NONE;
    ln_bad    = 1'b0;
    ln_space  = 1'b0;
  endfunction

  function automatic void take_token_char(logic [7:0] c);
    int          off;
    int          v;
    int          plen;
    int          k;
    logic [63:0] d;
    off = ln_off;
    if (ln_tok == TOK_KIND) begin
      if (off == 0) ln_cand = 4'b0011;
      for (k = 0; k < 2; k++)
        if (!(off < kind_word[k].len() && c == kind_word[k][off])) ln_cand[k] = 1'b0;
      if (ln_cand == '0) ln_bad = 1'b1;
      return;
    end
    if (ln_tok > TOK_REASON) begin
      ln_bad = 1'b1;
      return;
    end
    plen = prefix_word[ln_tok - 1].len();
    if (off < plen) begin
      if (c != prefix_word[ln_tok - 1][off]) ln_bad = 1'b1;
      return;
    end
    v = off - plen;
    case (ln_tok)
      TOK_REVISION: begin
        if (c < CH_ZERO || c > CH_NINE) begin
          ln_bad = 1'b1;
          return;
        end
        d = 64'(c - CH_ZERO);
        // no leading zero, and no wrap past 64 bits
        if ((v == 0 && d == 0) || ln_rev > ({64{1'b1}} - d) / 10) ln_bad = 1'b1;
        else ln_rev = ln_rev * 10 + d;
      end
      TOK_ACTIVE, TOK_ROLLBACK, TOK_STAGED: begin
        if (v == 0) begin
          if (c == CH_DASH) ln_cand = 4'b0001;
          else if (hex_digit(c)) ln_cand = 4'b0000;
          else ln_bad = 1'b1;
        end else if (ln_cand[0] || v >= DIGEST_LEN || !hex_digit(c)) begin
          ln_bad = 1'b1;
        end
      end
      TOK_DURABLE: begin
        if (v == 0 && (c == CH_ZERO || c == CH_ONE)) ln_dur = (c == CH_ONE);
        else ln_bad = 1'b1;
      end
      default: begin
        if (v == 0) ln_cand = 4'b0111;
        for (k = 0; k < 3; k++)
          if (!(v < reason_word[k].len() && c == reason_word[k][v])) ln_cand[k] = 1'b0;
        if (ln_cand == '0) ln_bad = 1'b1;
      end
    endcase
  endfunction

  function automatic void close_token();
    int off;
    int v;
    int plen;
    int k;
    off = ln_off;
    if (ln_tok == TOK_KIND) begin
      if (ln_cand[0] && off == KIND_OK_LEN) ln_err = 1'b0;
      else if (ln_cand[1] && off == KIND_ERR_LEN) ln_err = 1'b1;
      else ln_bad = 1'b1;
      return;
    end
    if (ln_tok > TOK_REASON) begin
      ln_bad = 1'b1;
      return;
    end
    plen = prefix_word[ln_tok - 1].len();
    if (off <= plen) begin
      ln_bad = 1'b1;
      return;
    end
    v = off - plen;
    case (ln_tok)
      TOK_ACTIVE, TOK_ROLLBACK, TOK_STAGED: begin
        if (!((ln_cand[0] && v == 1) || (!ln_cand[0] && v == DIGEST_LEN))) ln_bad = 1'b1;
      end
      TOK_DURABLE: begin
        if (v != 1) ln_bad = 1'b1;
      end
      TOK_REASON: begin
        ln_reason = REASON_NONE;
        for (k = 0; k < 3; k++)
          if (ln_cand[k] && v == reason_word[k].len()) ln_reason = reason_e'(2'(k + 1));
        if (ln_reason == REASON_NONE) ln_bad = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Advances the line state by one byte; returns 1 when the byte closes a line.
  function automatic bit parse_status_byte(input logic [7:0] c, input bit last,
                                           output slv_result_t res);
    res = '0;
    if (!last) begin
      if (ln_bad) return 1'b0;
      if (c < CH_PRINT_LO || c > CH_PRINT_HI) begin
        ln_bad = 1'b1;
        return 1'b0;
      end
      if (c == CH_SPACE) begin
        if (ln_off == 0 || ln_tok >= TOK_REASON) begin
          ln_bad = 1'b1;
          return 1'b0;
        end
        close_token();
        ln_tok   = ln_tok + 3'd1;
        ln_off   = 0;
        ln_cand  = '0;
        ln_space = 1'b1;
        return 1'b0;
      end
      ln_space = 1'b0;
      take_token_char(c);
      if (ln_off < OFFSET_MAX) ln_off++;
      return 1'b0;
    end
    if (!ln_bad) begin
      if (c != CH_NL || ln_space || ln_off == 0) begin
        ln_bad = 1'b1;
      end else begin
        close_token();
        if (ln_tok != TOK_REASON) ln_bad = 1'b1;
      end
    end
    if (!ln_bad) begin
      if (!ln_err) begin
        if (ln_reason != REASON_OK) ln_bad = 1'b1;
      end else if (ln_reason != REASON_REFUSED && ln_reason != REASON_UNCERTAIN) begin
        ln_bad = 1'b1;
      end
      if (ln_reason == REASON_UNCERTAIN && ln_dur) ln_bad = 1'b1;
    end
    if (ln_bad) begin
      res = '{VERDICT_BAD, 64'd0, 1'b0};
    end else begin
      res.verdict      = ln_err ? VERDICT_ERR : VERDICT_OK;
      res.revision     = ln_rev;
      res.durable_flag = ln_dur;
    end
    clear_line();
    return 1'b1;
  endfunction

  function automatic void add_text(string txt);
    for (int n = 0; n < txt.len(); n++)
      case (txt[n])
        "#": for (int j = 0; j < DIGEST_LEN; j++)
               line_buf.push_back(8'(hex_chars[(j * 7) % 16]));
        "%": repeat (140) line_buf.push_back(8'("a"));
        "@": for (int j = 0; j < reason_word[2].len(); j++)
               line_buf.push_back(8'(reason_word[2][j]));
        default: line_buf.push_back(8'(txt[n]));
      endcase
  endfunction

  // Mostly well-formed lines with random content, some mutated, some pure noise.
  task automatic build_random_line();
    int          mode;
    int          kind;
    int          rsn;
    int          pos;
    logic [63:0] rv;
    mode = $urandom_range(0, 99);
    line_buf.delete();
    if (mode >= 90) begin
      repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) line_buf.push_back(CH_NL);
      return;
    end
    kind = $urandom_range(0, 1);
    add_text(kind_word[kind]);
    add_text(" revision=");
    if ($urandom_range(0, 9) == 0) begin
      // around the 64-bit ceiling: last digit 5 fits, 6..9 overflow
      add_text($sformatf("1844674407370955161%0d", $urandom_range(5, 9)));
    end else begin
      rv = {$urandom, $urandom} >> $urandom_range(0, 63);
      add_text($sformatf("%0d", rv));
    end
    for (int t = TOK_ACTIVE; t <= TOK_STAGED; t++) begin
      add_text(" ");
      add_text(prefix_word[t - 1]);
      if ($urandom_range(0, 2) != 0) line_buf.push_back(CH_DASH);
      else repeat (DIGEST_LEN) line_buf.push_back(8'(hex_chars[$urandom_range(0, 15)]));
    end
    add_text($urandom_range(0, 1) != 0 ? " durable=1 reason=" : " durable=0 reason=");
    if ($urandom_range(0, 7) == 0) rsn = $urandom_range(0, 2);
    else if (kind != 0) rsn = $urandom_range(1, 2);
    else rsn = 0;
    add_text(reason_word[rsn]);
    line_buf.push_back(CH_NL);
    if (mode >= 70) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 3))
        0:       line_buf[pos] = 8'($urandom_range(0, 255));
        1:       line_buf.delete(pos);
        2:       line_buf.insert(pos, 8'($urandom_range(32, 126)));
        default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
      endcase
    end
  endtask

  task automatic send_line(input bit use_fixed, input slv_result_t fixed_res);
    slv_result_t res;
    bit          last;
    for (int n = 0; n < line_buf.size(); n++) begin
      last = (n == line_buf.size() - 1);
      while ($urandom_range(0, 99) < idle_pct) begin
        src_valid <= 1'b0;
        @(posedge clk_i);
      end
      src_valid <= 1'b1;
      src_byte  <= line_buf[n];
      src_last  <= last;
      @(posedge clk_i);
      while (!byte_if.ready) @(posedge clk_i);
      items_sent++;
      if (parse_status_byte(line_buf[n], last, res))
        verdict_q.push_back(use_fixed ? fixed_res : res);
    end
  endtask

  task automatic wait_for_verdicts();
    src_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_verdict_beat();
    slv_result_t want;
    if (verdict_q.size() == 0) begin
      $error("verdict beat with nothing pending: verdict %0d revision %0d durable %0d",
             result_if.verdict, result_if.revision, result_if.durable_flag);
      mismatches++;
      return;
    end
    want = verdict_q.pop_front();
    if (result_if.verdict !== want.verdict) begin
      $error("verdict: expected %0d, got %0d", want.verdict, result_if.verdict);
      mismatches++;
    end
    if (result_if.revision !== want.revision) begin
      $error("revision: expected %0d, got %0d", want.revision, result_if.revision);
      mismatches++;
    end
    if (result_if.durable_flag !== want.durable_flag) begin
      $error("durable_flag: expected %0d, got %0d", want.durable_flag,
             result_if.durable_flag);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && sink_ready) check_verdict_beat();
      sink_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((src_valid && byte_if.ready) || (result_if.valid && sink_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int ph;
    int lines;
    int base_items;
    clear_line();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      line_buf.delete();
      add_text(dir_line[i]);
      send_line(dir_exp[i].fixed, dir_exp[i].res);
    end
    // hold the sender off until every verdict is back
    wait_for_verdicts();

    for (ph = 0; ph < 4; ph++) begin
      idle_pct   = phase_idle[ph];
      stall_pct  = phase_stall[ph];
      base_items = items_sent;
      lines      = 0;
      while (items_sent - base_items < PHASE_ITEMS || lines < PHASE_LINES) begin
        build_random_line();
        send_line(1'b0, '0);
        lines++;
      end
      wait_for_verdicts();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
